// ===== hdl/shs_pkg.sv =====
// Package for the sorted handle set: operation and status codes, the
// sequencer state type and the command word sent down the row of cells.
// Depends on nothing; every other file of the block imports it.
package shs_pkg;

   // Fixed widths of the stream fields.
   localparam int unsigned REQ_DATA_WIDTH = 64;
   localparam int unsigned REQ_USER_WIDTH = 2;
   localparam int unsigned RSP_FIELD_WIDTH = 7;
   localparam int unsigned RSP_DATA_WIDTH = 16;
   localparam int unsigned RSP_USER_WIDTH = 3;

   // Operation requested.
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_CHECK  = 2'd2
   } kind_type;

   // Status returned with each response.
   typedef enum logic [2:0] {
      STATUS_ADDED     = 3'd0,
      STATUS_PRESENT   = 3'd1,
      STATUS_NULL      = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_REMOVED   = 3'd4,
      STATUS_NOT_FOUND = 3'd5,
      STATUS_VALID     = 3'd6
   } status_type;

   // Request sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE    = 2'd0,
      SEQ_COMPARE = 2'd1,
      SEQ_UPDATE  = 2'd2
   } seq_state_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } chain_cmd_type;

endpackage : shs_pkg

// ===== hdl/shs_cell.sv =====
// One cell of the sorted row: holds a single handle, compares it with the
// request handle and shifts left or right with its neighbours.
// Depends on shs_pkg.
module shs_cell #(
   parameter int unsigned INDEX        = 0,
   parameter int unsigned COUNT_WIDTH  = 7,
   parameter int unsigned HANDLE_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  shs_pkg::chain_cmd_type    cmd,
   input  logic [HANDLE_WIDTH-1:0]   handle,
   input  logic [COUNT_WIDTH-1:0]    count,
   input  logic [HANDLE_WIDTH-1:0]   left_entry,
   input  logic                      left_less,
   input  logic [HANDLE_WIDTH-1:0]   right_entry,
   output logic [HANDLE_WIDTH-1:0]   entry,
   output logic                      less,
   output logic                      equal
);
   import shs_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MY_INDEX = COUNT_WIDTH'(INDEX);

   logic [HANDLE_WIDTH-1:0] entry_ff;
   logic [HANDLE_WIDTH-1:0] entry_in;
   logic                    less_ff;
   logic                    less_in;
   logic                    equal_ff;
   logic                    equal_in;
   logic                    occupied;

   // The cell holds a live handle when its place lies below the count.
   assign occupied = (MY_INDEX < count);

   // Compare flags are taken in the compare cycle and held for the update.
   always_comb begin
      less_in  = less_ff;
      equal_in = equal_ff;
      if (cmd.compare) begin
         less_in  = occupied && (entry_ff < handle);
         equal_in = occupied && (entry_ff == handle);
      end
   end

   // Cells at or above the insertion point move right; the boundary cell
   // takes the new handle. On removal they pull from the right instead.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !less_ff) begin
         entry_in = left_less ? handle : left_entry;
      end else if (cmd.remove && !less_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         less_ff  <= 1'b0;
         equal_ff <= 1'b0;
      end else begin
         less_ff  <= less_in;
         equal_ff <= equal_in;
      end
   end

   // The stored handle needs no reset: cells at or above the count are never used.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign less  = less_ff;
   assign equal = equal_ff;

endmodule : shs_cell

// ===== hdl/shs_chain.sv =====
// Row of sorting cells with the encoder that turns the registered compare
// flags into the lower-bound position and the found flag.
// Depends on shs_pkg and shs_cell.
module shs_chain #(
   parameter int unsigned CAPACITY     = 64,
   parameter int unsigned COUNT_WIDTH  = 7,
   parameter int unsigned HANDLE_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  shs_pkg::chain_cmd_type    cmd,
   input  logic [HANDLE_WIDTH-1:0]   handle,
   input  logic [COUNT_WIDTH-1:0]    count,
   output logic [COUNT_WIDTH-1:0]    position,
   output logic                      found
);
   import shs_pkg::*;

   logic [CAPACITY-1:0][HANDLE_WIDTH-1:0] entries;
   logic [CAPACITY-1:0]                   less_flags;
   logic [CAPACITY-1:0]                   equal_flags;
   logic [CAPACITY-1:0]                   boundary;

   // The row of cells, each wired to its two neighbours.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [HANDLE_WIDTH-1:0] left_entry;
      logic                    left_less;
      logic [HANDLE_WIDTH-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = handle;
         assign left_less  = 1'b1;
      end else begin : g_inner_left
         assign left_entry = entries[g-1];
         assign left_less  = less_flags[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = entries[g];
      end else begin : g_inner_right
         assign right_entry = entries[g+1];
      end

      shs_cell #(
         .INDEX        (g),
         .COUNT_WIDTH  (COUNT_WIDTH),
         .HANDLE_WIDTH (HANDLE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .handle      (handle),
         .count       (count),
         .left_entry  (left_entry),
         .left_less   (left_less),
         .right_entry (right_entry),
         .entry       (entries[g]),
         .less        (less_flags[g]),
         .equal       (equal_flags[g])
      );

      // The less flags form a thermometer; its edge marks the lower bound.
      assign boundary[g] = !less_flags[g] && left_less;
   end

   // One-hot to binary over the boundary marks; a full run of smaller
   // handles puts the lower bound past the last cell.
   always_comb begin
      position = less_flags[CAPACITY-1] ? COUNT_WIDTH'(CAPACITY) : '0;
      found    = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            position = position | COUNT_WIDTH'(i);
         end
         found = found | (boundary[i] & equal_flags[i]);
      end
   end

endmodule : shs_chain

// ===== hdl/sorted_handle_set.sv =====
// Top level of the sorted handle set: request sequencer, count register,
// status decode and the registered response stage.
// Depends on shs_pkg and shs_chain (which uses shs_cell).
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_tvalid/req_tready  tdata: handle; tuser: kind
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: position, count; tuser: status
//
// A request passes a compare state, in which every cell compares its handle with the
// request, and then an update state, in which the row shifts and the response is loaded.
// A new request can be taken in the update state of the last one, once the response
// register is free; the response is registered when that update commits.
// Reset empties the set; the stored handles themselves are not cleared.
// A stalled response holds the update cycle until the response register frees.
module sorted_handle_set #(
   parameter int unsigned CAPACITY     = 64,
   parameter int unsigned HANDLE_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [shs_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,  // [63:0] handle_value
   input  logic [shs_pkg::REQ_USER_WIDTH-1:0]   req_tuser,  // [1:0] kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [shs_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,  // [6:0] position,
                                                            // [13:7] entry_count
   output logic [shs_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser   // [2:0] status
);
   import shs_pkg::*;

   localparam int unsigned COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = COUNT_WIDTH'(CAPACITY);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);
   localparam int unsigned RSP_PAD = RSP_DATA_WIDTH - 2 * RSP_FIELD_WIDTH;

   seq_state_type               state_ff;
   seq_state_type               state_in;
   logic [1:0]                  kind_ff;
   logic [HANDLE_WIDTH-1:0]     handle_ff;
   logic [COUNT_WIDTH-1:0]      count_ff;
   logic [COUNT_WIDTH-1:0]      count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   status_type                  rsp_status_ff;
   logic [RSP_FIELD_WIDTH-1:0]  rsp_position_ff;
   logic [RSP_FIELD_WIDTH-1:0]  rsp_count_ff;
   logic                        req_accept;
   logic                        out_free;
   logic                        commit;
   chain_cmd_type               cmd;
   logic [COUNT_WIDTH-1:0]      position;
   logic                        found;
   status_type                  status;

   // Row of cells holding the sorted handles.
   shs_chain #(
      .CAPACITY     (CAPACITY),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .handle   (handle_ff),
      .count    (count_ff),
      .position (position),
      .found    (found)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign commit     = (state_ff == SEQ_UPDATE) && out_free;

   // Status decode from the registered compare results.
   always_comb begin
      if (handle_ff == '0) begin
         status = STATUS_NULL;
      end else begin
         case (kind_ff)
            KIND_ADD: begin
               if (found) begin
                  status = STATUS_PRESENT;
               end else if (count_ff >= COUNT_FULL) begin
                  status = STATUS_FULL;
               end else begin
                  status = STATUS_ADDED;
               end
            end
            KIND_REMOVE: begin
               status = found ? STATUS_REMOVED : STATUS_NOT_FOUND;
            end
            default: begin
               status = found ? STATUS_VALID : STATUS_NOT_FOUND;
            end
         endcase
      end
   end

   // Commands to the row and the count after this request.
   always_comb begin
      cmd.compare = (state_ff == SEQ_COMPARE);
      cmd.insert  = commit && (status == STATUS_ADDED);
      cmd.remove  = commit && (status == STATUS_REMOVED);
      count_in    = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_ONE;
      end else if (cmd.remove) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   // Sequencer: next state and request ready.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = SEQ_COMPARE;
            end
         end
         SEQ_COMPARE: begin
            state_in = SEQ_UPDATE;
         end
         SEQ_UPDATE: begin
            req_tready = out_free;
            if (out_free) begin
               state_in = req_tvalid ? SEQ_COMPARE : SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff   <= req_tuser;
         handle_ff <= req_tdata[HANDLE_WIDTH-1:0];
      end
      if (commit) begin
         rsp_status_ff   <= status;
         rsp_position_ff <= RSP_FIELD_WIDTH'(position);
         rsp_count_ff    <= RSP_FIELD_WIDTH'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_count_ff, rsp_position_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("stored count exceeds capacity");

   // A committed insert grows the set by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + COUNT_ONE))
      else $error("insert did not advance the count");

   // A committed remove shrinks the set by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> (count_ff == $past(count_ff) - COUNT_ONE))
      else $error("remove did not reduce the count");

   // No request is taken while the row is comparing.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_COMPARE) |-> !req_tready)
      else $error("request accepted during compare");

   // A null handle is always answered at position zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_NULL) |-> (rsp_position_ff == '0))
      else $error("null handle answered at a nonzero position");

endmodule : sorted_handle_set
